// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold whenever reset is released
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rpuf_pkg.sv =====
// ---------------------------------------------------------------------------
// rpuf_pkg
// Shared types and constants for the range-parallel union-find core.
// ---------------------------------------------------------------------------
package rpuf_pkg;

    localparam logic [29:0] PRIME = 30'd998244353;

    // element and level counts are fixed by the item field widths
    localparam int ELEMENT_COUNT = 1024;
    localparam int LEVEL_COUNT   = 11;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_UNION = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [9:0]  index_a;
        logic [9:0]  index_b;
        logic [10:0] length;
        logic [29:0] weight;
    } item_t;

    typedef struct packed {
        logic [29:0] total;
        logic        range_error;
    } result_t;

    // modular add of two values below the prime
    function automatic logic [29:0] mod_add(input logic [29:0] x, input logic [29:0] y);
        logic [30:0] s;
        logic [30:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, PRIME};
        mod_add = d[30] ? s[29:0] : d[29:0];
    endfunction

endpackage

// ===== rtl/rpuf_stream_if.sv =====
// ---------------------------------------------------------------------------
// rpuf_stream_if
// Valid/ready channel carrying one payload of parametric type.
// ---------------------------------------------------------------------------
interface rpuf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/rpuf_mulmod.sv =====
// ---------------------------------------------------------------------------
// rpuf_mulmod
// Sequential modular multiplier: one shift-add-reduce step per cycle.
// ---------------------------------------------------------------------------
module rpuf_mulmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [29:0] op_x,
    input  logic [29:0] op_y,
    output logic        busy,
    output logic [29:0] product
);

    logic [29:0] acc_reg, acc_next;
    logic [29:0] y_reg;
    logic [29:0] x_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [29:0] dbl;

    // acc = 2*acc + bit*y, all mod prime, msb first
    always_comb
    begin
        dbl = rpuf_pkg::mod_add(acc_reg, acc_reg);
        acc_next = x_reg[29] ? rpuf_pkg::mod_add(dbl, y_reg) : dbl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd29;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= op_x;
            y_reg   <= op_y;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            x_reg   <= {x_reg[28:0], 1'b0};
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/range_parallel_union_find_core.sv =====
// ---------------------------------------------------------------------------
// range_parallel_union_find_core
// Range-parallel union-find with weighted level-0 merge totals.
// ---------------------------------------------------------------------------
// One item at a time. After reset a clearing pass initializes the parent/size
// memory and the weight memory; no item is taken during it. A union pops its
// pending merges one by one; a find walks one parent hop at a time and path
// compression rewrites one node at a time, since every step goes through the
// single-port state memory; each level-0 merge that joins two sets adds the
// weight reads and the bit-serial modular multiply. The time a union takes
// grows with the number of pushed-down merges. The result beat sits in its own
// register, so the next item can be taken while it waits.
`include "assert_macros.svh"

module range_parallel_union_find_core (
    input  logic clk,
    input  logic rst_n,
    rpuf_stream_if.sink   in_ch,
    rpuf_stream_if.source out_ch
);

    localparam int ELEMENT_COUNT = rpuf_pkg::ELEMENT_COUNT;
    localparam int LEVEL_COUNT   = rpuf_pkg::LEVEL_COUNT;
    localparam int EW    = $clog2(ELEMENT_COUNT);
    localparam int LW    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int DEPTH = LEVEL_COUNT * ELEMENT_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SD    = 2 * LEVEL_COUNT + 2;
    localparam int SW    = $clog2(SD + 1);
    localparam int SZW   = EW + 1;

    typedef struct packed {
        logic [EW-1:0] a;
        logic [EW-1:0] b;
        logic [LW-1:0] level;
    } pend_t;

    typedef struct packed {
        logic [EW-1:0]  parent;
        logic [SZW-1:0] size;
    } node_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_POP,
        S_FA_RD, S_FA_WT, S_FA_CHK, S_CA_RD, S_CA_WT, S_CA_WR,
        S_FB_RD, S_FB_WT, S_FB_CHK, S_CB_RD, S_CB_WT, S_CB_WR,
        S_SZ_RD, S_SZ_WT, S_SZ_B, S_W_RD, S_W_WT, S_W_B, S_MUL, S_MUL_WT,
        S_MERGE, S_PUSH, S_OUT
    } state_t;

    // ---------------- memories ----------------
    node_t         node_mem [DEPTH];
    logic [29:0]   wmem [ELEMENT_COUNT];
    pend_t         stack_mem [SD];

    logic          nm_we;
    logic [AW-1:0] nm_addr;
    node_t         nm_wdata, nm_rdata;
    logic          wm_we;
    logic [EW-1:0] wm_addr;
    logic [29:0]   wm_wdata, wm_rdata;

    always_ff @(posedge clk)
    begin
        if (nm_we)
            node_mem[nm_addr] <= nm_wdata;
        nm_rdata <= node_mem[nm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
            wmem[wm_addr] <= wm_wdata;
        wm_rdata <= wmem[wm_addr];
    end

    // ---------------- registers ----------------
    state_t          state_reg;
    logic [AW-1:0]   clr_reg;
    logic [EW-1:0]   clr_el_reg;
    rpuf_pkg::item_t item_reg;
    logic [29:0]     total_reg;
    logic            err_reg;
    logic [SW-1:0]   sp_reg;
    pend_t           cur_reg;
    logic [AW-1:0]   base_reg;
    logic [EW-1:0]   x_reg, ra_reg, rb_reg;
    logic [SZW-1:0]  sa_reg, sb_reg;
    logic [29:0]     wa_reg, wb_reg;
    logic            out_valid_reg;
    logic [29:0]     out_total_reg;
    logic            out_err_reg;
    logic            start_reg;
    logic [SW-1:0]   sp_push;
    logic            mul_start;
    logic            mul_busy;
    logic [29:0]     mul_prod;

    rpuf_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_x    (wa_reg),
        .op_y    (wb_reg),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    // level decode of the union length
    logic [LW-1:0]  k_lvl;
    logic [10:0]    blk;
    logic [10:0]    off;
    logic [11:0]    end_a, end_b;
    logic           range_bad;
    always_comb
    begin
        k_lvl = '0;
        for (int i = 1; i < 11; i++)
        begin
            if (item_reg.length[i])
                k_lvl = (i >= LEVEL_COUNT) ? LW'(LEVEL_COUNT - 1) : LW'(i);
        end
        blk = 11'd1 << k_lvl;
        off = item_reg.length - blk;
        end_a = {2'b00, item_reg.index_a} + {1'b0, item_reg.length};
        end_b = {2'b00, item_reg.index_b} + {1'b0, item_reg.length};
        range_bad = (end_a > 12'(ELEMENT_COUNT)) || (end_b > 12'(ELEMENT_COUNT));
    end

    function automatic logic [AW-1:0] node_addr(input logic [AW-1:0] base,
                                                input logic [EW-1:0] el);
        node_addr = base + AW'(el);
    endfunction

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.payload.total = out_total_reg;
    assign out_ch.payload.range_error = out_err_reg;

    logic [EW-1:0] half;
    assign half = EW'(1) << (cur_reg.level - LW'(1));

    // memory port drive
    always_comb
    begin
        nm_we    = 1'b0;
        nm_addr  = node_addr(base_reg, x_reg);
        nm_wdata = '0;
        wm_we    = 1'b0;
        wm_addr  = ra_reg;
        wm_wdata = '0;
        mul_start = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                nm_we    = 1'b1;
                nm_addr  = clr_reg;
                nm_wdata = '{parent: clr_el_reg, size: SZW'(1)};
                wm_we    = 1'b1;
                wm_addr  = clr_el_reg;
                wm_wdata = '0;
            end
            S_LOAD:
            begin
                wm_we    = item_reg.index_a < EW'(ELEMENT_COUNT - 1) ||
                           item_reg.index_a == EW'(ELEMENT_COUNT - 1);
                wm_addr  = item_reg.index_a[EW-1:0];
                wm_wdata = (item_reg.weight >= rpuf_pkg::PRIME) ?
                           item_reg.weight - rpuf_pkg::PRIME : item_reg.weight;
            end
            S_CA_WR:
            begin
                nm_we    = 1'b1;
                nm_wdata = '{parent: ra_reg, size: nm_rdata.size};
            end
            S_CB_WR:
            begin
                nm_we    = 1'b1;
                nm_wdata = '{parent: rb_reg, size: nm_rdata.size};
            end
            S_SZ_RD:  nm_addr = node_addr(base_reg, ra_reg);
            S_SZ_WT:  nm_addr = node_addr(base_reg, rb_reg);
            S_W_RD:   wm_addr = ra_reg;
            S_W_WT:   wm_addr = rb_reg;
            S_MUL:    mul_start = 1'b1;
            S_MERGE:
            begin
                // winner is ra after swap; write loser parent then winner size
                nm_we    = 1'b1;
                nm_addr  = node_addr(base_reg, rb_reg);
                nm_wdata = '{parent: ra_reg, size: sb_reg};
                if (cur_reg.level == '0)
                begin
                    wm_we    = 1'b1;
                    wm_addr  = ra_reg;
                    wm_wdata = rpuf_pkg::mod_add(wa_reg, wb_reg);
                end
            end
            S_PUSH:
            begin
                // the decode pass of a new union touches no node
                if (!start_reg)
                begin
                    nm_we    = 1'b1;
                    nm_addr  = node_addr(base_reg, ra_reg);
                    nm_wdata = '{parent: ra_reg, size: sa_reg + sb_reg};
                end
            end
            default: ;
        endcase
    end

    // stack pointer after the pushes of the push slot
    always_comb
    begin
        sp_push = sp_reg;
        if (start_reg)
            sp_push = (item_reg.length != '0 && !range_bad &&
                       item_reg.index_a != item_reg.index_b) ? SW'(2) : SW'(0);
        else if (cur_reg.level != '0)
            sp_push = sp_reg + SW'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clr_el_reg    <= '0;
            sp_reg        <= '0;
            total_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg    <= clr_reg + AW'(1);
                    clr_el_reg <= (clr_el_reg == EW'(ELEMENT_COUNT - 1)) ? '0 :
                                  clr_el_reg + EW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        item_reg  <= in_ch.payload;
                        // a union first passes the push slot to seed the stack
                        state_reg <= (in_ch.payload.kind == rpuf_pkg::KIND_LOAD) ?
                                     S_LOAD : S_PUSH;
                        sp_reg <= '0;
                    end
                end
                S_LOAD: state_reg <= S_IDLE;
                S_POP:
                begin
                    if (sp_reg == '0)
                        state_reg <= S_OUT;
                    else
                    begin
                        cur_reg   <= stack_mem[sp_reg - SW'(1)];
                        base_reg  <= AW'(stack_mem[sp_reg - SW'(1)].level) *
                                     AW'(ELEMENT_COUNT);
                        x_reg     <= stack_mem[sp_reg - SW'(1)].a;
                        sp_reg    <= sp_reg - SW'(1);
                        state_reg <= S_FA_RD;
                    end
                end
                // find root of a
                S_FA_RD: state_reg <= S_FA_WT;
                S_FA_WT: state_reg <= S_FA_CHK;
                S_FA_CHK:
                begin
                    if (nm_rdata.parent == x_reg)
                    begin
                        ra_reg    <= x_reg;
                        x_reg     <= cur_reg.a;
                        state_reg <= S_CA_RD;
                    end
                    else
                    begin
                        x_reg     <= nm_rdata.parent;
                        state_reg <= S_FA_WT;
                    end
                end
                // compress path of a
                S_CA_RD: state_reg <= (x_reg == ra_reg) ? S_FB_RD : S_CA_WT;
                S_CA_WT: state_reg <= S_CA_WR;
                S_CA_WR:
                begin
                    x_reg     <= nm_rdata.parent;
                    state_reg <= S_CA_RD;
                end
                S_FB_RD:
                begin
                    x_reg     <= cur_reg.b;
                    state_reg <= S_FB_WT;
                end
                S_FB_WT: state_reg <= S_FB_CHK;
                S_FB_CHK:
                begin
                    if (nm_rdata.parent == x_reg)
                    begin
                        rb_reg    <= x_reg;
                        x_reg     <= cur_reg.b;
                        state_reg <= S_CB_RD;
                    end
                    else
                    begin
                        x_reg     <= nm_rdata.parent;
                        state_reg <= S_FB_WT;
                    end
                end
                S_CB_RD: state_reg <= (x_reg == rb_reg) ? S_SZ_RD : S_CB_WT;
                S_CB_WT: state_reg <= S_CB_WR;
                S_CB_WR:
                begin
                    x_reg     <= nm_rdata.parent;
                    state_reg <= S_CB_RD;
                end
                // fetch sizes of both roots
                S_SZ_RD: state_reg <= (ra_reg == rb_reg) ? S_POP : S_SZ_WT;
                S_SZ_WT:
                begin
                    sa_reg    <= nm_rdata.size;
                    state_reg <= S_SZ_B;
                end
                S_SZ_B:
                begin
                    state_reg <= (cur_reg.level == '0) ? S_W_RD : S_MERGE;
                    if (nm_rdata.size > sa_reg)
                    begin
                        ra_reg <= rb_reg;
                        rb_reg <= ra_reg;
                        sa_reg <= nm_rdata.size;
                        sb_reg <= sa_reg;
                    end
                    else
                        sb_reg <= nm_rdata.size;
                end
                S_W_RD: state_reg <= S_W_WT;
                S_W_WT:
                begin
                    wa_reg    <= wm_rdata;
                    state_reg <= S_W_B;
                end
                S_W_B:
                begin
                    wb_reg    <= wm_rdata;
                    state_reg <= S_MUL;
                end
                S_MUL: state_reg <= S_MUL_WT;
                S_MUL_WT:
                begin
                    if (!mul_busy)
                    begin
                        total_reg <= rpuf_pkg::mod_add(total_reg, mul_prod);
                        state_reg <= S_MERGE;
                    end
                end
                S_MERGE: state_reg <= S_PUSH;
                S_PUSH:
                begin
                    sp_reg    <= sp_push;
                    state_reg <= S_POP;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result register, loaded when the previous beat has left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_err_reg   <= 1'b0;
        end
        else if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
        begin
            out_valid_reg <= 1'b1;
            out_total_reg <= total_reg;
            out_err_reg   <= err_reg;
        end
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // union decode and pushdown, tracked by a start flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= 1'b0;
        else if (state_reg == S_IDLE && in_ch.valid && in_ch.ready)
            start_reg <= (in_ch.payload.kind == rpuf_pkg::KIND_UNION);
        else if (state_reg == S_PUSH)
            start_reg <= 1'b0;
    end

    // stack writes and the error flag; these override the merge push slot
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PUSH)
        begin
            if (start_reg)
            begin
                err_reg <= (item_reg.length != '0) && range_bad;
                if (item_reg.length != '0 && !range_bad &&
                    item_reg.index_a != item_reg.index_b)
                begin
                    stack_mem[0] <= '{a: item_reg.index_a[EW-1:0] + EW'(off),
                                      b: item_reg.index_b[EW-1:0] + EW'(off),
                                      level: k_lvl};
                    stack_mem[1] <= '{a: item_reg.index_a[EW-1:0],
                                      b: item_reg.index_b[EW-1:0], level: k_lvl};
                end
            end
            else if (cur_reg.level != '0)
            begin
                stack_mem[sp_reg]          <= '{a: cur_reg.a + half, b: cur_reg.b + half,
                                                level: cur_reg.level - LW'(1)};
                stack_mem[sp_reg + SW'(1)] <= '{a: cur_reg.a, b: cur_reg.b,
                                                level: cur_reg.level - LW'(1)};
            end
        end
    end

    `ASSERT_ALWAYS(a_sp_bound, sp_reg <= SW'(SD), "stack overflow")
    `ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
    `ASSERT_NEXT(a_out_stable, out_ch.valid && !out_ch.ready, $stable(out_ch.payload), "result changed while waiting")

endmodule
